// File: rtl/tpg_pkg.sv
// Package for the turtle pen plotter grid: command codes, heading codes,
// result kinds and the controller state type. No dependencies.
`timescale 1ns / 1ps

package tpg_pkg;

   localparam int GRID_SIZE_DEF = 20;

   localparam logic [7:0] CMD_PEN_UP   = 8'd1;
   localparam logic [7:0] CMD_PEN_DOWN = 8'd2;
   localparam logic [7:0] CMD_RIGHT    = 8'd3;
   localparam logic [7:0] CMD_LEFT     = 8'd4;
   localparam logic [7:0] CMD_MOVE     = 8'd5;
   localparam logic [7:0] CMD_DUMP     = 8'd6;
   localparam logic [7:0] CMD_END      = 8'd9;

   localparam logic [1:0] HEAD_EAST  = 2'd0;
   localparam logic [1:0] HEAD_SOUTH = 2'd1;
   localparam logic [1:0] HEAD_WEST  = 2'd2;
   localparam logic [1:0] HEAD_NORTH = 2'd3;

   localparam logic KIND_ROW = 1'b0;
   localparam logic KIND_BAD = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MV_RD,
      ST_MV_WR,
      ST_DUMP_RD,
      ST_DUMP_LD,
      ST_BAD
   } tpg_state_type;

endpackage

// File: rtl/tpg_grid_mem.sv
// Grid row memory: one row per entry, synchronous (registered) read.
// Per-row valid flags make never-written rows read as cleared. Uses tpg_pkg.
`timescale 1ns / 1ps

module tpg_grid_mem
   import tpg_pkg::*;
#(
   parameter int GRID_SIZE = GRID_SIZE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [$clog2(GRID_SIZE)-1:0] rd_addr,
   output logic [GRID_SIZE-1:0]         rd_data,
   input  logic                         wr_en,
   input  logic [$clog2(GRID_SIZE)-1:0] wr_addr,
   input  logic [GRID_SIZE-1:0]         wr_data
);

   logic [GRID_SIZE-1:0] mem [GRID_SIZE];
   logic [GRID_SIZE-1:0] row_valid_ff;
   logic [GRID_SIZE-1:0] rd_q_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

// File: rtl/tpg_ctrl.sv
// Plotter sequencer: decodes commands, keeps pen, heading and position, walks
// moves and dumps through the grid memory. Uses tpg_pkg.
`timescale 1ns / 1ps

module tpg_ctrl
   import tpg_pkg::*;
#(
   parameter int GRID_SIZE = GRID_SIZE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_command,
   input  logic [9:0]                   req_steps,
   input  logic                         req_batch_end,
   input  logic                         rsp_free,
   output logic                         rd_en,
   output logic [$clog2(GRID_SIZE)-1:0] rd_addr,
   input  logic [GRID_SIZE-1:0]         rd_data,
   output logic                         wr_en,
   output logic [$clog2(GRID_SIZE)-1:0] wr_addr,
   output logic [GRID_SIZE-1:0]         wr_data,
   output logic                         ld_en,
   output logic                         ld_kind,
   output logic [5:0]                   ld_row_index,
   output logic [GRID_SIZE-1:0]         ld_row_bits,
   output logic [7:0]                   ld_bad_command,
   output logic                         ld_last
);

   localparam int PW = $clog2(GRID_SIZE);
   localparam int CW = $clog2(GRID_SIZE + 1);
   localparam logic [PW-1:0] POS_MAX = PW'(GRID_SIZE - 1);

   tpg_state_type state_ff, state_in;

   logic [PW-1:0] col_ff, col_in;
   logic [PW-1:0] row_ff, row_in;
   logic [1:0]    heading_ff, heading_in;
   logic          pen_ff, pen_in;
   logic          skip_ff, skip_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] dump_row_ff, dump_row_in;
   logic [7:0]    bad_ff, bad_in;

   logic accept;
   logic live;

   assign accept = req_valid && req_ready;
   assign live   = accept && !skip_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (live) begin
               priority case (req_command)
                  CMD_PEN_UP, CMD_PEN_DOWN, CMD_RIGHT, CMD_LEFT, CMD_END:
                     state_in = ST_IDLE;
                  CMD_MOVE:
                     state_in = (req_steps != 10'd0) ? ST_MV_RD : ST_IDLE;
                  CMD_DUMP:
                     state_in = ST_DUMP_RD;
                  default:
                     state_in = ST_BAD;
               endcase
            end
         end
         ST_MV_RD:   state_in = ST_MV_WR;
         ST_MV_WR:   state_in = (count_ff == CW'(1)) ? ST_IDLE : ST_MV_RD;
         ST_DUMP_RD: state_in = rsp_free ? ST_DUMP_LD : ST_DUMP_RD;
         ST_DUMP_LD: state_in = (dump_row_ff == POS_MAX) ? ST_IDLE : ST_DUMP_RD;
         ST_BAD:     state_in = rsp_free ? ST_IDLE : ST_BAD;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      rd_en          = (state_ff == ST_MV_RD) || ((state_ff == ST_DUMP_RD) && rsp_free);
      rd_addr        = (state_ff == ST_MV_RD) ? row_ff : dump_row_ff;
      wr_en          = (state_ff == ST_MV_WR) && pen_ff;
      wr_addr        = row_ff;
      wr_data        = rd_data | (GRID_SIZE'(1) << col_ff);
      ld_en          = (state_ff == ST_DUMP_LD) || ((state_ff == ST_BAD) && rsp_free);
      ld_kind        = (state_ff == ST_BAD) ? KIND_BAD : KIND_ROW;
      ld_row_index   = (state_ff == ST_BAD) ? 6'd0 : 6'(dump_row_ff);
      ld_row_bits    = (state_ff == ST_BAD) ? '0 : rd_data;
      ld_bad_command = (state_ff == ST_BAD) ? bad_ff : 8'd0;
      ld_last        = (state_ff == ST_BAD) || (dump_row_ff == POS_MAX);
   end

   // datapath next values
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      heading_in  = heading_ff;
      pen_in      = pen_ff;
      skip_in     = skip_ff;
      count_in    = count_ff;
      dump_row_in = dump_row_ff;
      bad_in      = bad_ff;
      if (live) begin
         priority case (req_command)
            CMD_PEN_UP:   pen_in = 1'b0;
            CMD_PEN_DOWN: pen_in = 1'b1;
            CMD_RIGHT:    heading_in = heading_ff + 2'd1;
            CMD_LEFT:     heading_in = heading_ff + 2'd3;
            CMD_MOVE:     count_in = (req_steps > 10'(GRID_SIZE)) ?
                                     CW'(GRID_SIZE) : CW'(req_steps);
            CMD_DUMP:     dump_row_in = '0;
            CMD_END:      skip_in = 1'b1;
            default:      bad_in = req_command;
         endcase
      end
      if (accept && req_batch_end) begin
         skip_in = 1'b0;
      end
      if (state_ff == ST_MV_WR) begin
         count_in = count_ff - CW'(1);
         unique case (heading_ff)
            HEAD_EAST:  if (col_ff != POS_MAX) col_in = col_ff + PW'(1);
            HEAD_SOUTH: if (row_ff != POS_MAX) row_in = row_ff + PW'(1);
            HEAD_WEST:  if (col_ff != '0) col_in = col_ff - PW'(1);
            HEAD_NORTH: if (row_ff != '0) row_in = row_ff - PW'(1);
            default:    col_in = col_ff;
         endcase
      end
      if ((state_ff == ST_DUMP_LD) && (dump_row_ff != POS_MAX)) begin
         dump_row_in = dump_row_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         col_ff      <= '0;
         row_ff      <= '0;
         heading_ff  <= HEAD_EAST;
         pen_ff      <= 1'b0;
         skip_ff     <= 1'b0;
         count_ff    <= '0;
         dump_row_ff <= '0;
      end else begin
         state_ff    <= state_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         heading_ff  <= heading_in;
         pen_ff      <= pen_in;
         skip_ff     <= skip_in;
         count_ff    <= count_in;
         dump_row_ff <= dump_row_in;
      end
   end

   always_ff @(posedge clock) begin
      bad_ff <= bad_in;
   end

endmodule

// File: rtl/turtle_pen_plotter_grid_top.sv
// Turtle pen plotter grid, top level: sequencer, grid row memory and the
// result register. Uses tpg_pkg, tpg_grid_mem and tpg_ctrl.
`timescale 1ns / 1ps

// A GRID_SIZE x GRID_SIZE turtle plotter; the grid lives in a row memory with
// a registered read and reads as cleared after reset (per-row valid flags,
// no clearing pass). One item is handled at a time. A move walks at most
// GRID_SIZE steps: each step reads the current row and then, with the pen down,
// writes it back marked. A dump reads each row in turn and loads it as a result,
// waiting while the result register is full; an invalid command loads one
// result the same way. Results wait in an output register until rsp_ready
// takes them.
module turtle_pen_plotter_grid_top
   import tpg_pkg::*;
#(
   parameter int GRID_SIZE = GRID_SIZE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_command,
   input  logic [9:0]           req_steps,
   input  logic                 req_batch_end,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_kind,
   output logic [5:0]           rsp_row_index,
   output logic [GRID_SIZE-1:0] rsp_row_bits,
   output logic [7:0]           rsp_bad_command,
   output logic                 rsp_last
);

   localparam int PW = $clog2(GRID_SIZE);

   logic                 rd_en;
   logic [PW-1:0]        rd_addr;
   logic [GRID_SIZE-1:0] rd_data;
   logic                 wr_en;
   logic [PW-1:0]        wr_addr;
   logic [GRID_SIZE-1:0] wr_data;

   logic                 ld_en;
   logic                 ld_kind;
   logic [5:0]           ld_row_index;
   logic [GRID_SIZE-1:0] ld_row_bits;
   logic [7:0]           ld_bad_command;
   logic                 ld_last;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 kind_ff;
   logic [5:0]           row_index_ff;
   logic [GRID_SIZE-1:0] row_bits_ff;
   logic [7:0]           bad_command_ff;
   logic                 last_ff;
   logic                 rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   tpg_ctrl #(
      .GRID_SIZE(GRID_SIZE)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_steps      (req_steps),
      .req_batch_end  (req_batch_end),
      .rsp_free       (rsp_free),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .ld_en          (ld_en),
      .ld_kind        (ld_kind),
      .ld_row_index   (ld_row_index),
      .ld_row_bits    (ld_row_bits),
      .ld_bad_command (ld_bad_command),
      .ld_last        (ld_last)
   );

   tpg_grid_mem #(
      .GRID_SIZE(GRID_SIZE)
   ) u_grid_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ld_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_en) begin
         kind_ff        <= ld_kind;
         row_index_ff   <= ld_row_index;
         row_bits_ff    <= ld_row_bits;
         bad_command_ff <= ld_bad_command;
         last_ff        <= ld_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_row_index   = row_index_ff;
   assign rsp_row_bits    = row_bits_ff;
   assign rsp_bad_command = bad_command_ff;
   assign rsp_last        = last_ff;

endmodule
